FILE: hdl/pgss_pkg.sv
// Shared types, constants and helper functions for the periodic Gaussian seed stamper.
`timescale 1ns / 1ps
`default_nettype none
package pgss_pkg;

   localparam int LATTICE_X_DEF = 64;
   localparam int LATTICE_Y_DEF = 64;
   localparam int LATTICE_Z_DEF = 64;

   localparam int COORD_W    = 6;
   localparam int PHI_W      = 32;
   localparam int DELTA_W    = 8;
   localparam int R2_W       = 14;
   localparam int AMP_W      = 31;
   localparam int THR_W      = 31;
   localparam int SAFE_W     = 14;
   localparam int COEF_W     = 24;
   localparam int X_W        = COEF_W + R2_W;
   localparam int REM_W      = 29;
   localparam int N_W        = 5;
   localparam int T_W        = 30;
   localparam int ACC_W      = 31;
   localparam int PROD_W     = 60;
   localparam int PR_W       = 62;
   localparam int AMPG_W     = 62;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [REM_W-1:0] LN2_Q24   = 29'd11629080;
   localparam logic [X_W-1:0]   EXP_LIMIT = 38'd360501480;
   localparam logic [ACC_W-1:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [AMPG_W-1:0] HALF_Q30 = 62'h2000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z,
      CSR_AMPLITUDE,
      CSR_THRESHOLD,
      CSR_SAFE_DIST_SQ,
      CSR_GAUSS_COEF
   } csr_index_type;

   typedef enum logic {
      OP_CHECK,
      OP_STAMP
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULX,
      ST_RANGE,
      ST_DIV,
      ST_HMUL,
      ST_HREC,
      ST_HFIX,
      ST_SHIFT,
      ST_AMP,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      op_type                   op;
      logic                     last;
      logic signed [PHI_W-1:0]  phi;
      logic [R2_W-1:0]          r2;
      logic                     blocked;
   } entry_type;

   typedef struct packed {
      logic [AMP_W-1:0]  amplitude;
      logic [COEF_W-1:0] gauss_coef;
   } cfg_type;

   // floor(2^32 / k), saturated for k = 1; the caller corrects by one
   function automatic logic [31:0] recip(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd1:    r = 32'hFFFF_FFFF;
         4'd2:    r = 32'h8000_0000;
         4'd3:    r = 32'd1431655765;
         4'd4:    r = 32'h4000_0000;
         4'd5:    r = 32'd858993459;
         4'd6:    r = 32'd715827882;
         4'd7:    r = 32'd613566756;
         4'd8:    r = 32'h2000_0000;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/pgss_ifs.sv
// Channel interfaces: site requests, results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface pgss_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic [pgss_pkg::COORD_W-1:0]         site_x;
   logic [pgss_pkg::COORD_W-1:0]         site_y;
   logic [pgss_pkg::COORD_W-1:0]         site_z;
   logic signed [pgss_pkg::PHI_W-1:0]    site_phi;
   logic                                 last;
   modport source (output valid, op, site_x, site_y, site_z, site_phi, last, input ready);
   modport sink   (input valid, op, site_x, site_y, site_z, site_phi, last, output ready);
endinterface

interface pgss_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pgss_pkg::PHI_W-1:0]    new_phi;
   logic                                 blocked;
   logic                                 verdict_ok;
   logic                                 last_out;
   modport source (output valid, new_phi, blocked, verdict_ok, last_out, input ready);
   modport sink   (input valid, new_phi, blocked, verdict_ok, last_out, output ready);
endinterface

interface pgss_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [pgss_pkg::CSR_IDX_W-1:0]       index;
   logic [pgss_pkg::CSR_DATA_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/pgss_front.sv
// Front end: register file, periodic distance, blocking test, queue push.
`timescale 1ns / 1ps
`default_nettype none
module pgss_front #(
   parameter int LATTICE_X = pgss_pkg::LATTICE_X_DEF,
   parameter int LATTICE_Y = pgss_pkg::LATTICE_Y_DEF,
   parameter int LATTICE_Z = pgss_pkg::LATTICE_Z_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   pgss_req_if.sink           req_ch,
   pgss_csr_if.sink           csr_ch,
   input  wire logic          q_full,
   output logic               q_push,
   output pgss_pkg::entry_type q_entry,
   output pgss_pkg::cfg_type  cfg
);

   localparam int LAT_MAX = (LATTICE_X > LATTICE_Y) ?
                            ((LATTICE_X > LATTICE_Z) ? LATTICE_X : LATTICE_Z) :
                            ((LATTICE_Y > LATTICE_Z) ? LATTICE_Y : LATTICE_Z);
   localparam int LW_RAW  = $clog2(LAT_MAX + 1) + 1;
   localparam int LW      = (LW_RAW > pgss_pkg::DELTA_W) ? LW_RAW : pgss_pkg::DELTA_W;

   logic [pgss_pkg::COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [pgss_pkg::AMP_W-1:0]   amp_ff;
   logic [pgss_pkg::THR_W-1:0]   thr_ff;
   logic [pgss_pkg::SAFE_W-1:0]  safe_ff;
   logic [pgss_pkg::COEF_W-1:0]  coef_ff;

   logic signed [pgss_pkg::DELTA_W-1:0] dx, dy, dz;
   logic signed [15:0]                  sqx, sqy, sqz;
   logic [pgss_pkg::R2_W-1:0]           r2;
   logic signed [pgss_pkg::PHI_W:0]     phe;
   logic [pgss_pkg::PHI_W:0]            mag;

   function automatic logic signed [pgss_pkg::DELTA_W-1:0] axis_delta(
      input logic [pgss_pkg::COORD_W-1:0] s,
      input logic [pgss_pkg::COORD_W-1:0] c,
      input int len
   );
      logic [pgss_pkg::COORD_W:0]   d;
      logic [pgss_pkg::COORD_W-1:0] direct;
      logic signed [LW-1:0]         dir_s;
      logic signed [LW-1:0]         wrap;
      d      = {1'b0, s} - {1'b0, c};
      direct = d[pgss_pkg::COORD_W] ? pgss_pkg::COORD_W'(-d) : d[pgss_pkg::COORD_W-1:0];
      dir_s  = signed'(LW'(direct));
      wrap   = signed'(LW'(len)) - dir_s;
      return (dir_s < wrap) ? pgss_pkg::DELTA_W'(dir_s) : pgss_pkg::DELTA_W'(wrap);
   endfunction

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         cz_ff   <= '0;
         amp_ff  <= 31'd65536;
         thr_ff  <= 31'd3;
         safe_ff <= '0;
         coef_ff <= '0;
      end else if (csr_ch.valid) begin
         case (pgss_pkg::csr_index_type'(csr_ch.index))
            pgss_pkg::CSR_CENTER_X:     cx_ff   <= csr_ch.data[pgss_pkg::COORD_W-1:0];
            pgss_pkg::CSR_CENTER_Y:     cy_ff   <= csr_ch.data[pgss_pkg::COORD_W-1:0];
            pgss_pkg::CSR_CENTER_Z:     cz_ff   <= csr_ch.data[pgss_pkg::COORD_W-1:0];
            pgss_pkg::CSR_AMPLITUDE:    amp_ff  <= csr_ch.data[pgss_pkg::AMP_W-1:0];
            pgss_pkg::CSR_THRESHOLD:    thr_ff  <= csr_ch.data[pgss_pkg::THR_W-1:0];
            pgss_pkg::CSR_SAFE_DIST_SQ: safe_ff <= csr_ch.data[pgss_pkg::SAFE_W-1:0];
            pgss_pkg::CSR_GAUSS_COEF:   coef_ff <= csr_ch.data[pgss_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dx  = axis_delta(req_ch.site_x, cx_ff, LATTICE_X);
      dy  = axis_delta(req_ch.site_y, cy_ff, LATTICE_Y);
      dz  = axis_delta(req_ch.site_z, cz_ff, LATTICE_Z);
      sqx = dx * dx;
      sqy = dy * dy;
      sqz = dz * dz;
      r2  = pgss_pkg::R2_W'(sqx[11:0]) + pgss_pkg::R2_W'(sqy[11:0])
          + pgss_pkg::R2_W'(sqz[11:0]);
      phe = {req_ch.site_phi[pgss_pkg::PHI_W-1], req_ch.site_phi};
      mag = phe[pgss_pkg::PHI_W] ? (pgss_pkg::PHI_W+1)'(-phe) : (pgss_pkg::PHI_W+1)'(phe);
   end

   assign req_ch.ready     = ~q_full;
   assign q_push           = req_ch.valid & ~q_full;
   assign q_entry.op       = pgss_pkg::op_type'(req_ch.op);
   assign q_entry.last     = req_ch.last;
   assign q_entry.phi      = req_ch.site_phi;
   assign q_entry.r2       = r2;
   assign q_entry.blocked  = (r2 < safe_ff) && (mag > {2'b00, thr_ff});
   assign cfg.amplitude    = amp_ff;
   assign cfg.gauss_coef   = coef_ff;

endmodule
`default_nettype wire

FILE: hdl/pgss_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module pgss_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pgss_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     head_valid,
   output pgss_pkg::entry_type      head
);

   pgss_pkg::entry_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full       = cnt_ff[1];
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hdl/pgss_back.sv
// Back end: pass verdict, fixed-point Gaussian sequencer, saturating add, result register.
`timescale 1ns / 1ps
`default_nettype none
module pgss_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire pgss_pkg::entry_type q_head,
   output logic                     q_pop,
   input  wire pgss_pkg::cfg_type   cfg,
   pgss_rsp_if.source               rsp_ch
);

   pgss_pkg::back_state_type state_ff, state_in;
   pgss_pkg::entry_type      cur_ff;

   logic [pgss_pkg::X_W-1:0]    x_ff;
   logic [pgss_pkg::REM_W-1:0]  rem_ff;
   logic [pgss_pkg::N_W-1:0]    n_ff;
   logic [2:0]                  bit_ff;
   logic                        zero_ff;
   logic [3:0]                  k_ff;
   logic [pgss_pkg::T_W-1:0]    t_ff;
   logic [pgss_pkg::ACC_W-1:0]  acc_ff;
   logic [pgss_pkg::PROD_W-1:0] prod_ff;
   logic [pgss_pkg::T_W-1:0]    p_ff;
   logic [pgss_pkg::PR_W-1:0]   pr_ff;
   logic [pgss_pkg::ACC_W-1:0]  g_ff;
   logic [pgss_pkg::AMPG_W-1:0] ampg_ff;
   logic                        running_ok_ff;

   logic                        rsp_valid_ff;
   logic signed [pgss_pkg::PHI_W-1:0] rsp_phi_ff;
   logic                        rsp_blocked_ff, rsp_ok_ff, rsp_last_ff;

   logic out_free, load_check, load_stamp;

   logic [pgss_pkg::REM_W-1:0]  ln2_sh, rem_nx;
   logic                        div_ge;
   logic [pgss_pkg::T_W-1:0]    p_nx;
   logic [pgss_pkg::T_W-1:0]    q0;
   logic [33:0]                 qk, rmd;
   logic [pgss_pkg::ACC_W-1:0]  q;
   logic [pgss_pkg::AMPG_W-1:0] rnd;
   logic [pgss_pkg::PHI_W-1:0]  addv;
   logic signed [33:0]          sum;
   logic signed [pgss_pkg::PHI_W-1:0] stamp_phi;
   logic                        ok_upd;

   assign out_free = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgss_pkg::ST_IDLE:
            if (q_valid && out_free && q_head.op == pgss_pkg::OP_STAMP)
               state_in = pgss_pkg::ST_MULX;
         pgss_pkg::ST_MULX:  state_in = pgss_pkg::ST_RANGE;
         pgss_pkg::ST_RANGE:
            state_in = (x_ff >= pgss_pkg::EXP_LIMIT) ? pgss_pkg::ST_SHIFT : pgss_pkg::ST_DIV;
         pgss_pkg::ST_DIV:
            if (bit_ff == 3'd0) state_in = pgss_pkg::ST_HMUL;
         pgss_pkg::ST_HMUL:  state_in = pgss_pkg::ST_HREC;
         pgss_pkg::ST_HREC:  state_in = pgss_pkg::ST_HFIX;
         pgss_pkg::ST_HFIX:
            state_in = (k_ff == 4'd1) ? pgss_pkg::ST_SHIFT : pgss_pkg::ST_HMUL;
         pgss_pkg::ST_SHIFT: state_in = pgss_pkg::ST_AMP;
         pgss_pkg::ST_AMP:   state_in = pgss_pkg::ST_DONE;
         pgss_pkg::ST_DONE:
            if (out_free) state_in = pgss_pkg::ST_IDLE;
         default:            state_in = pgss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = (state_ff == pgss_pkg::ST_IDLE) && q_valid && out_free;
      load_check = q_pop && (q_head.op == pgss_pkg::OP_CHECK);
      load_stamp = (state_ff == pgss_pkg::ST_DONE) && out_free;
   end

   always_comb begin
      ln2_sh = pgss_pkg::LN2_Q24 << bit_ff;
      div_ge = (rem_ff >= ln2_sh);
      rem_nx = div_ge ? rem_ff - ln2_sh : rem_ff;
      p_nx   = prod_ff[pgss_pkg::PROD_W-1:30];
      q0     = pr_ff[pgss_pkg::PR_W-1:32];
      qk     = 34'(q0) * 34'(k_ff);
      rmd    = 34'(p_ff) - qk;
      q      = (rmd >= 34'(k_ff)) ? pgss_pkg::ACC_W'(q0) + 31'd1 : pgss_pkg::ACC_W'(q0);
      rnd    = ampg_ff + pgss_pkg::HALF_Q30;
      addv   = rnd[pgss_pkg::AMPG_W-1:30];
      sum    = 34'(cur_ff.phi) + signed'({2'b00, addv});
      stamp_phi = (sum > 34'sd2147483647) ? 32'sh7FFF_FFFF : sum[pgss_pkg::PHI_W-1:0];
      ok_upd = running_ok_ff & ~q_head.blocked;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         pgss_pkg::ST_IDLE:
            if (q_pop) cur_ff <= q_head;
         pgss_pkg::ST_MULX:
            x_ff <= pgss_pkg::X_W'(cfg.gauss_coef) * pgss_pkg::X_W'(cur_ff.r2);
         pgss_pkg::ST_RANGE: begin
            zero_ff <= (x_ff >= pgss_pkg::EXP_LIMIT);
            rem_ff  <= x_ff[pgss_pkg::REM_W-1:0];
            n_ff    <= '0;
            bit_ff  <= 3'd4;
         end
         pgss_pkg::ST_DIV: begin
            rem_ff <= rem_nx;
            n_ff   <= n_ff | (pgss_pkg::N_W'(div_ge) << bit_ff);
            bit_ff <= bit_ff - 3'd1;
            t_ff   <= {rem_nx[23:0], 6'b000000};
            acc_ff <= pgss_pkg::ONE_Q30;
            k_ff   <= 4'd8;
         end
         pgss_pkg::ST_HMUL:
            prod_ff <= pgss_pkg::PROD_W'(t_ff) * pgss_pkg::PROD_W'(acc_ff);
         pgss_pkg::ST_HREC: begin
            p_ff  <= p_nx;
            pr_ff <= pgss_pkg::PR_W'(p_nx) * pgss_pkg::PR_W'(pgss_pkg::recip(k_ff));
         end
         pgss_pkg::ST_HFIX: begin
            acc_ff <= pgss_pkg::ONE_Q30 - q;
            k_ff   <= k_ff - 4'd1;
         end
         pgss_pkg::ST_SHIFT:
            g_ff <= zero_ff ? '0 : acc_ff >> n_ff;
         pgss_pkg::ST_AMP:
            ampg_ff <= pgss_pkg::AMPG_W'(cfg.amplitude) * pgss_pkg::AMPG_W'(g_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pgss_pkg::ST_IDLE;
         running_ok_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_check) begin
            running_ok_ff <= q_head.last ? 1'b1 : ok_upd;
         end else if (load_stamp && cur_ff.last) begin
            running_ok_ff <= 1'b1;
         end
         if (load_check || load_stamp) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_check) begin
         rsp_phi_ff     <= q_head.phi;
         rsp_blocked_ff <= q_head.blocked;
         rsp_ok_ff      <= ok_upd;
         rsp_last_ff    <= q_head.last;
      end else if (load_stamp) begin
         rsp_phi_ff     <= stamp_phi;
         rsp_blocked_ff <= 1'b0;
         rsp_ok_ff      <= running_ok_ff;
         rsp_last_ff    <= cur_ff.last;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.new_phi    = rsp_phi_ff;
   assign rsp_ch.blocked    = rsp_blocked_ff;
   assign rsp_ch.verdict_ok = rsp_ok_ff;
   assign rsp_ch.last_out   = rsp_last_ff;

endmodule
`default_nettype wire

FILE: hdl/periodic_gaussian_seed_stamper.sv
// Check-mode beats: queue, then result register; one beat per cycle while rsp_ch is ready.
// Stamp-mode beats run the back-end sequencer (5 range-reduction steps and 8 Horner
// steps of HMUL, HREC and HFIX, then shift, amplitude multiply and add).
// Stamp beats are handled one at a time; the 2-entry queue buffers intake until it fills.
// Synchronous active-high reset restores register defaults and sets the pass verdict to 1.
`timescale 1ns / 1ps
`default_nettype none
module periodic_gaussian_seed_stamper #(
   parameter int LATTICE_X = pgss_pkg::LATTICE_X_DEF,
   parameter int LATTICE_Y = pgss_pkg::LATTICE_Y_DEF,
   parameter int LATTICE_Z = pgss_pkg::LATTICE_Z_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pgss_req_if.sink   req_ch,
   pgss_rsp_if.source rsp_ch,
   pgss_csr_if.sink   csr_ch
);

   logic                q_full, q_push, q_pop, q_valid;
   pgss_pkg::entry_type q_entry, q_head;
   pgss_pkg::cfg_type   cfg;

   pgss_front #(
      .LATTICE_X (LATTICE_X),
      .LATTICE_Y (LATTICE_Y),
      .LATTICE_Z (LATTICE_Z)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .csr_ch  (csr_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_entry),
      .cfg     (cfg)
   );

   pgss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   pgss_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .cfg     (cfg),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire
